FILE: src/key_sorter_assert.svh
// Assertion macros shared by the key sorter modules.
// Each module that includes this file must have clk and arst_n in scope.
`ifndef KEY_SORTER_ASSERT_SVH
`define KEY_SORTER_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define KS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("key_sorter assertion failed");

// Checks that a condition holds in the cycle after a trigger.
`define KS_ASSERT_NEXT(label, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("key_sorter assertion failed");

`endif

FILE: src/ks_pkg.sv
// Package for the key sorter: widths, capacity, control struct and states.
// Used by ks_cell, ks_ctrl and key_sorter; depends on nothing else.
package ks_pkg;

	localparam int DEPTH = 64;
	localparam int KEY_W = 32;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic {
		ST_LOAD,
		ST_UNLOAD
	} state_t;

	// Control broadcast from the sequencer to every cell of the chain.
	typedef struct packed {
		logic insert;
		logic shift;
		logic descending;
	} cell_ctl_t;

endpackage

FILE: src/ks_cell.sv
// One cell of the sorting chain: holds a key and its valid bit.
// Depends on ks_pkg for the key width and the control struct.
module ks_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ks_pkg::cell_ctl_t       ctl,
	input  logic [ks_pkg::KEY_W-1:0] new_key,
	input  logic                    prev_ins,
	input  logic                    prev_valid,
	input  logic [ks_pkg::KEY_W-1:0] prev_key,
	input  logic                    next_valid,
	input  logic [ks_pkg::KEY_W-1:0] next_key,
	output logic                    ins,
	output logic                    valid,
	output logic [ks_pkg::KEY_W-1:0] key
);

	logic                     valid_q;
	logic [ks_pkg::KEY_W-1:0] key_q;
	logic                     goes_before;

	// The new key belongs ahead of the stored one in the chosen order.
	assign goes_before = ctl.descending ? (new_key > key_q) : (new_key < key_q);
	assign ins         = !valid_q || goes_before;
	assign valid       = valid_q;
	assign key         = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.insert) begin
			if (prev_ins) begin
				valid_q <= prev_valid;
			end else if (ins) begin
				valid_q <= 1'b1;
			end
		end else if (ctl.shift) begin
			valid_q <= next_valid;
		end
	end

	// On insert the chain opens at the first cell whose key comes later:
	// that cell takes the new key and every cell after it takes its left neighbor.
	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (prev_ins) begin
				key_q <= prev_key;
			end else if (ins) begin
				key_q <= new_key;
			end
		end else if (ctl.shift) begin
			key_q <= next_key;
		end
	end

endmodule

FILE: src/ks_ctrl.sv
// Sequencer of the key sorter: load and unload phases, key count,
// overflow flag and the order register. Depends on ks_pkg.
`include "key_sorter_assert.svh"

module ks_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic              m_tlast,
	output logic              m_tuser,
	output ks_pkg::cell_ctl_t ctl
);

	ks_pkg::state_t           state_q;
	ks_pkg::state_t           state_nxt;
	logic [ks_pkg::CNT_W-1:0] count_q;
	logic                     dropped_q;
	logic                     descending_q;
	logic                     in_acc;
	logic                     out_acc;
	logic                     has_room;
	logic                     is_final;

	assign in_acc   = s_tvalid && s_tready;
	assign out_acc  = m_tvalid && m_tready;
	assign has_room = count_q < ks_pkg::CNT_W'(ks_pkg::DEPTH);
	assign is_final = count_q == ks_pkg::CNT_W'(1);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ks_pkg::ST_LOAD: begin
				if (in_acc && s_tlast) begin
					state_nxt = ks_pkg::ST_UNLOAD;
				end
			end
			ks_pkg::ST_UNLOAD: begin
				if (out_acc && is_final) begin
					state_nxt = ks_pkg::ST_LOAD;
				end
			end
			default: state_nxt = ks_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		s_tready       = 1'b0;
		m_tvalid       = 1'b0;
		m_tlast        = 1'b0;
		m_tuser        = 1'b0;
		ctl.insert     = 1'b0;
		ctl.shift      = 1'b0;
		ctl.descending = descending_q;
		case (state_q)
			ks_pkg::ST_LOAD: begin
				s_tready   = 1'b1;
				ctl.insert = in_acc && has_room;
			end
			ks_pkg::ST_UNLOAD: begin
				m_tvalid  = 1'b1;
				m_tlast   = is_final;
				m_tuser   = dropped_q;
				ctl.shift = out_acc;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ks_pkg::ST_LOAD;
			count_q      <= '0;
			dropped_q    <= 1'b0;
			descending_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid && cfg_ready) begin
				descending_q <= cfg_data;
			end
			if (in_acc) begin
				if (has_room) begin
					count_q <= count_q + ks_pkg::CNT_W'(1);
				end else begin
					dropped_q <= 1'b1;
				end
			end else if (out_acc) begin
				count_q <= count_q - ks_pkg::CNT_W'(1);
				if (is_final) begin
					dropped_q <= 1'b0;
				end
			end
		end
	end

	`KS_ASSERT(a_count_bound, count_q <= ks_pkg::CNT_W'(ks_pkg::DEPTH))
	`KS_ASSERT(a_unload_nonempty, m_tvalid |-> count_q != '0)
	`KS_ASSERT_NEXT(a_last_starts_unload, in_acc && s_tlast, m_tvalid)

endmodule

FILE: src/key_sorter.sv
// Key sorter top level: a chain of ks_cell sorting cells and the ks_ctrl sequencer.
// Depends on ks_pkg, ks_cell, ks_ctrl and key_sorter_assert.svh.
//
// Usage: keys enter on the s_ channel, one per item, with s_tlast on the final
// key of a set. Each accepted key is inserted into the sorted cell chain in the
// same cycle, so the next key can follow at once. Up to 64 keys are kept; later
// keys of the set are dropped and every result of that set has m_tuser set.
// In the cycle after the last key, the sorted set leaves on the m_ channel from
// the head of the chain, one item per cycle while m_tready is high, m_tlast on
// the final one. While results are pending s_tready is low; if the receiver
// stalls, the chain simply holds. cfg_data chooses descending order (1) or
// ascending (0); the user must see that it is written only while no set is in
// flight, as the block itself does not enforce this. Reset empties the chain,
// clears the count and overflow flag and selects ascending order.
`include "key_sorter_assert.svh"

module key_sorter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_data,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [ks_pkg::KEY_W-1:0]  s_tdata,  // key
	input  logic                      s_tlast,  // last
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [ks_pkg::KEY_W-1:0]  m_tdata,  // sorted_key
	output logic                      m_tlast,  // final_res
	output logic                      m_tuser   // overflow
);

	ks_pkg::cell_ctl_t          ctl;
	logic [ks_pkg::DEPTH-1:0]   cell_ins;
	logic [ks_pkg::DEPTH-1:0]   cell_valid;
	logic [ks_pkg::KEY_W-1:0]   cell_key [ks_pkg::DEPTH];

	ks_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.ctl       (ctl)
	);

	for (genvar i = 0; i < ks_pkg::DEPTH; i++) begin : g_cell
		logic                     p_ins;
		logic                     p_valid;
		logic [ks_pkg::KEY_W-1:0] p_key;
		logic                     n_valid;
		logic [ks_pkg::KEY_W-1:0] n_key;

		if (i == 0) begin : g_head
			assign p_ins   = 1'b0;
			assign p_valid = 1'b0;
			assign p_key   = '0;
		end else begin : g_body
			assign p_ins   = cell_ins[i-1];
			assign p_valid = cell_valid[i-1];
			assign p_key   = cell_key[i-1];
		end

		if (i == ks_pkg::DEPTH - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_key   = '0;
		end else begin : g_inner
			assign n_valid = cell_valid[i+1];
			assign n_key   = cell_key[i+1];
		end

		ks_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_key    (s_tdata),
			.prev_ins   (p_ins),
			.prev_valid (p_valid),
			.prev_key   (p_key),
			.next_valid (n_valid),
			.next_key   (n_key),
			.ins        (cell_ins[i]),
			.valid      (cell_valid[i]),
			.key        (cell_key[i])
		);
	end

	assign m_tdata = cell_key[0];

	`KS_ASSERT(a_head_valid, m_tvalid |-> cell_valid[0])
	`KS_ASSERT(a_chain_packed, !cell_valid[0] |-> !cell_valid[ks_pkg::DEPTH-1])
	`KS_ASSERT_NEXT(a_drained, m_tvalid && m_tready && m_tlast, !cell_valid[0])

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for key_sorter: streams sets of keys in, predicts each sorted
// set and its overflow marking, and checks every result item as it leaves.
// Depends on ks_pkg and the key_sorter RTL only.
`timescale 1ns / 100ps

module tb_top;

	localparam int CAP = ks_pkg::DEPTH;
	localparam int KW = ks_pkg::KEY_W;
	localparam int TAIL_CYCLES = 8;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		logic [KW-1:0] key;
		logic          last;
	} key_item_t;

	typedef struct {
		logic [KW-1:0] key;
		logic          fin;
		logic          ovf;
	} sorted_item_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic          cfg_data = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [KW-1:0] s_tdata = '0;  // key
	logic          s_tlast = 1'b0;  // last
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [KW-1:0] m_tdata;  // sorted_key
	logic          m_tlast;  // final_res
	logic          m_tuser;  // overflow

	key_item_t    keys_to_send[$];
	sorted_item_t sorted_expected[$];

	// Predictor state: the set being collected and the current sort direction.
	logic [KW-1:0] set_keys[CAP];
	int            set_count = 0;
	bit            set_dropped = 1'b0;
	bit            desc_order = 1'b0;

	int  src_idle_pct = 0;
	int  sink_stall_pct = 0;
	bit  key_taken = 1'b0;
	int  errors = 0;
	int  quiet_cycles = 0;
	int  keys_sent = 0;
	int  sets_done = 0;
	int  ovf_sets = 0;
	int  results_seen = 0;

	key_sorter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit out_of_order(logic [KW-1:0] a, logic [KW-1:0] b);
		return desc_order ? (a < b) : (a > b);
	endfunction

	// Collects one key; on the last key of a set, sorts the stored keys and queues
	// one expected result per stored key.
	function void sort_on_last(logic [KW-1:0] key, logic last);
		int i;
		int j;
		logic [KW-1:0] v;
		sorted_item_t r;
		if (set_count < CAP) begin
			set_keys[set_count] = key;
			set_count++;
		end else begin
			set_dropped = 1'b1;
		end
		if (last) begin
			for (i = 1; i < set_count; i++) begin
				v = set_keys[i];
				j = i;
				while (j > 0 && out_of_order(set_keys[j-1], v)) begin
					set_keys[j] = set_keys[j-1];
					j--;
				end
				set_keys[j] = v;
			end
			for (i = 0; i < set_count; i++) begin
				r.key = set_keys[i];
				r.fin = (i == set_count - 1);
				r.ovf = set_dropped;
				sorted_expected.push_back(r);
			end
			sets_done++;
			if (set_dropped)
				ovf_sets++;
			set_count = 0;
			set_dropped = 1'b0;
		end
	endfunction

	// Monitor: input and configuration handshakes feed the predictor, output items
	// are checked against the oldest expectation.
	always @(posedge clk) begin
		sorted_item_t exp_r;
		bit any_taken;
		any_taken = 1'b0;
		key_taken = s_tvalid && (s_tready === 1'b1);
		if (cfg_valid && cfg_ready === 1'b1) begin
			desc_order = cfg_data;
			any_taken = 1'b1;
		end
		if (key_taken) begin
			sort_on_last(s_tdata, s_tlast);
			keys_sent++;
			any_taken = 1'b1;
		end
		if (m_tvalid === 1'b1 && m_tready) begin
			any_taken = 1'b1;
			results_seen++;
			if (sorted_expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected result key=%h last=%b ovf=%b", $time,
					m_tdata, m_tlast, m_tuser);
			end else begin
				exp_r = sorted_expected.pop_front();
				if (m_tdata !== exp_r.key || m_tlast !== exp_r.fin ||
						m_tuser !== exp_r.ovf) begin
					errors++;
					$display("%0t: mismatch expected key=%h last=%b ovf=%b, actual key=%h last=%b ovf=%b",
						$time, exp_r.key, exp_r.fin, exp_r.ovf, m_tdata, m_tlast, m_tuser);
				end
			end
		end
		if (!arst_n || any_taken)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Key driver: a new item is offered only once the previous one was taken.
	always @(negedge clk) begin
		key_item_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || key_taken) begin
			if (keys_to_send.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
				it = keys_to_send.pop_front();
				s_tdata <= it.key;
				s_tlast <= it.last;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	function automatic logic [KW-1:0] pick_key();
		case ($urandom_range(3))
			0: return $urandom_range(7);
			1: begin
				case ($urandom_range(3))
					0: return '0;
					1: return '1;
					2: return {1'b1, {(KW-1){1'b0}}};
					default: return {1'b0, {(KW-1){1'b1}}};
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic add_key(logic [KW-1:0] key, logic last);
		key_item_t it;
		it.key = key;
		it.last = last;
		keys_to_send.push_back(it);
	endtask

	task automatic add_set(int size);
		for (int k = 0; k < size; k++)
			add_key(pick_key(), k == size - 1);
	endtask

	// Mostly short sets; now and then a set that fills or overruns the store.
	task automatic add_random_sets(int target);
		int n;
		int size;
		n = 0;
		while (n < target) begin
			if ($urandom_range(99) < 3)
				size = $urandom_range(CAP, CAP + 6);
			else
				size = $urandom_range(1, 12);
			add_set(size);
			n += size;
		end
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (keys_to_send.size() != 0 || s_tvalid || sorted_expected.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_order(logic desc);
		@(negedge clk);
		cfg_data <= desc;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Ascending, no idling, directed sets first.
		write_order(1'b0);
		src_idle_pct = 0;
		sink_stall_pct = 0;
		add_key('0, 1'b1);
		add_key('1, 1'b1);
		add_key('1, 1'b0);
		add_key('0, 1'b0);
		add_key({1'b1, {(KW-1){1'b0}}}, 1'b0);
		add_key(32'd1, 1'b0);
		add_key({1'b0, {(KW-1){1'b1}}}, 1'b0);
		add_key(32'h5555_5555, 1'b0);
		add_key(32'hAAAA_AAAA, 1'b1);
		add_key(32'd5, 1'b0);
		add_key(32'd5, 1'b0);
		add_key(32'd5, 1'b1);
		add_key(32'd9, 1'b0);
		add_key(32'd3, 1'b0);
		add_key(32'd9, 1'b1);
		add_random_sets(50);
		wait_idle();

		// Descending, sender idles; a full store and an overrun store, then a pause.
		write_order(1'b1);
		src_idle_pct = 50;
		add_key('0, 1'b0);
		add_key('1, 1'b0);
		add_key(32'd1, 1'b1);
		add_set(CAP);
		add_set(CAP + 2);
		wait_idle();
		add_random_sets(20);
		wait_idle();

		// Ascending, receiver stalls.
		write_order(1'b0);
		src_idle_pct = 0;
		sink_stall_pct = 50;
		add_set(CAP + 1);
		add_random_sets(50);
		wait_idle();

		// Descending, both sides idle.
		write_order(1'b1);
		src_idle_pct = 32;
		sink_stall_pct = 32;
		add_random_sets(50);
		wait_idle();

		$display("Sent %0d keys in %0d sets (%0d overran the store), checked %0d results,",
			keys_sent, sets_done, ovf_sets, results_seen);
		$display("in both sort orders, with and without idling on either side.");
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
